>>> sv/assert_macros.svh
// Assertion macros used by the k-mer extractor core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define KMERX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define KMERX_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

>>> sv/kmerx_pkg.sv
// Shared constants, types and helper functions for the k-mer extractor.
package kmerx_pkg;

    localparam int DEFAULT_MAX_K = 32;
    localparam int WORD_W        = 64;
    localparam int POS_W         = 40;
    localparam int K_W           = 6;
    localparam int SEL_W         = 2;
    localparam int BYTE_W        = 8;
    localparam int RUN_MAX       = 32;

    localparam logic [SEL_W-1:0] SEL_K8  = 2'd0;
    localparam logic [SEL_W-1:0] SEL_K16 = 2'd1;
    localparam logic [SEL_W-1:0] SEL_K32 = 2'd2;

    localparam logic [BYTE_W-1:0] CH_HEADER  = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_A       = 8'h41;
    localparam logic [BYTE_W-1:0] CH_C       = 8'h43;
    localparam logic [BYTE_W-1:0] CH_G       = 8'h47;
    localparam logic [BYTE_W-1:0] CH_T       = 8'h54;
    localparam logic [BYTE_W-1:0] CH_LOW_A   = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOW_Z   = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_BIT   = 8'h20;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    typedef struct packed {
        logic       shift;
        logic [1:0] code;
        logic [1:0] comp;
    } shift_ctl_t;

    function automatic logic [K_W-1:0] k_for_sel(input logic [SEL_W-1:0] sel);
        logic [K_W-1:0] k;
        unique case (sel)
            SEL_K8:  k = 6'd8;
            SEL_K16: k = 6'd16;
            default: k = 6'd32;
        endcase
        return k;
    endfunction

endpackage

>>> sv/kmerx_cell.sv
// One base slot of the forward and reverse-complement k-mer words.
module kmerx_cell #(
    parameter int IDX = 0
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  kmerx_pkg::shift_ctl_t      ctl,
    input  logic [kmerx_pkg::K_W-1:0]  k,
    input  logic [1:0]                 fwd_in,
    input  logic [1:0]                 rev_in,
    output logic [1:0]                 fwd_q,
    output logic [1:0]                 rev_q,
    output logic [1:0]                 fwd_next,
    output logic [1:0]                 rev_next
);

    logic [1:0] fwd_reg;
    logic [1:0] rev_reg;
    logic       active;
    logic       top;

    assign active = (k > kmerx_pkg::K_W'(IDX));
    assign top    = (k == kmerx_pkg::K_W'(IDX + 1));

    always_comb begin
        fwd_next = fwd_reg;
        rev_next = rev_reg;
        if (ctl.shift) begin
            if (!active) begin
                fwd_next = 2'b00;
                rev_next = 2'b00;
            end else begin
                fwd_next = fwd_in;
                rev_next = top ? ctl.comp : rev_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 2'b00;
            rev_reg <= 2'b00;
        end else begin
            fwd_reg <= fwd_next;
            rev_reg <= rev_next;
        end
    end

    assign fwd_q = fwd_reg;
    assign rev_q = rev_reg;

endmodule

>>> sv/kmerx_cell_row.sv
// Row of base cells that forms the forward and reverse-complement words.
module kmerx_cell_row #(
    parameter int MAX_K = kmerx_pkg::DEFAULT_MAX_K
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  kmerx_pkg::shift_ctl_t         ctl,
    input  logic [kmerx_pkg::K_W-1:0]     k,
    output logic [kmerx_pkg::WORD_W-1:0]  fwd_word_next,
    output logic [kmerx_pkg::WORD_W-1:0]  rev_word_next
);

    logic [1:0] fwd_q [MAX_K];
    logic [1:0] rev_q [MAX_K];

    for (genvar i = 0; i < MAX_K; i++) begin : g_cell
        logic [1:0] fwd_in;
        logic [1:0] rev_in;

        if (i == 0) begin : g_first
            assign fwd_in = ctl.code;
        end else begin : g_mid
            assign fwd_in = fwd_q[i-1];
        end

        if (i == MAX_K - 1) begin : g_last
            assign rev_in = 2'b00;
        end else begin : g_inner
            assign rev_in = rev_q[i+1];
        end

        kmerx_cell #(
            .IDX(i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .k        (k),
            .fwd_in   (fwd_in),
            .rev_in   (rev_in),
            .fwd_q    (fwd_q[i]),
            .rev_q    (rev_q[i]),
            .fwd_next (fwd_word_next[2*i+1:2*i]),
            .rev_next (rev_word_next[2*i+1:2*i])
        );
    end

    if (2 * MAX_K < kmerx_pkg::WORD_W) begin : g_pad
        assign fwd_word_next[kmerx_pkg::WORD_W-1:2*MAX_K] = '0;
        assign rev_word_next[kmerx_pkg::WORD_W-1:2*MAX_K] = '0;
    end

endmodule

>>> sv/kmer_extractor_revcomp_core.sv
// A result beat is valid in the cycle after the letter that causes it is accepted.
// Throughput: one text byte per cycle while the output is not held; the row of base cells shifts once per letter.
// The output register frees in the same cycle it is taken, so input never waits on a drained output.
// Reset is synchronous and active low; it clears the words, run length, position and header flag.
// Reset also sets the size selector to k=8.
`include "assert_macros.svh"

module kmer_extractor_revcomp_core #(
    parameter int MAX_K = kmerx_pkg::DEFAULT_MAX_K
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [kmerx_pkg::SEL_W-1:0]     cfg_wdata,   // kmer_size_select
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,     // text_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [167:0]                    m_tdata      // forward_kmer, reverse_kmer, base_position
);

    localparam logic [kmerx_pkg::K_W-1:0] K_CAP = kmerx_pkg::K_W'(MAX_K);
    localparam logic [kmerx_pkg::K_W-1:0] RUN_SAT = kmerx_pkg::K_W'(kmerx_pkg::RUN_MAX);

    logic [kmerx_pkg::SEL_W-1:0]  ksel_reg;
    logic                         in_header_reg;
    logic                         in_header_next;
    logic [kmerx_pkg::K_W-1:0]    run_reg;
    logic [kmerx_pkg::K_W-1:0]    run_next;
    logic [kmerx_pkg::POS_W-1:0]  pos_reg;
    logic [kmerx_pkg::POS_W-1:0]  pos_next;
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic [kmerx_pkg::WORD_W-1:0] fwd_out_reg;
    logic [kmerx_pkg::WORD_W-1:0] rev_out_reg;
    logic [kmerx_pkg::POS_W-1:0]  pos_out_reg;

    logic                         s_beat;
    logic [kmerx_pkg::BYTE_W-1:0] lc;
    logic                         is_letter;
    logic                         is_base;
    logic [1:0]                   code;
    logic                         emit;
    logic [kmerx_pkg::K_W-1:0]    k_sel;
    logic [kmerx_pkg::K_W-1:0]    k;
    kmerx_pkg::shift_ctl_t        ctl;
    logic [kmerx_pkg::WORD_W-1:0] fwd_word_next;
    logic [kmerx_pkg::WORD_W-1:0] rev_word_next;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_beat   = s_tvalid && s_tready;

    assign k_sel = kmerx_pkg::k_for_sel(ksel_reg);
    assign k     = (k_sel > K_CAP) ? K_CAP : k_sel;

    assign lc        = s_tdata | kmerx_pkg::CASE_BIT;
    assign is_letter = (lc >= kmerx_pkg::CH_LOW_A) && (lc <= kmerx_pkg::CH_LOW_Z);

    always_comb begin
        is_base = 1'b1;
        code    = kmerx_pkg::CODE_A;
        unique case (s_tdata)
            kmerx_pkg::CH_A: code = kmerx_pkg::CODE_A;
            kmerx_pkg::CH_C: code = kmerx_pkg::CODE_C;
            kmerx_pkg::CH_G: code = kmerx_pkg::CODE_G;
            kmerx_pkg::CH_T: code = kmerx_pkg::CODE_T;
            default:         is_base = 1'b0;
        endcase
    end

    always_comb begin
        in_header_next = in_header_reg;
        run_next       = run_reg;
        pos_next       = pos_reg;
        ctl.shift      = 1'b0;
        ctl.code       = code;
        ctl.comp       = is_base ? ~code : 2'b00;
        emit           = 1'b0;
        if (s_beat) begin
            if (in_header_reg) begin
                if (s_tdata == kmerx_pkg::CH_NEWLINE) begin
                    in_header_next = 1'b0;
                end
            end else if (s_tdata == kmerx_pkg::CH_HEADER) begin
                in_header_next = 1'b1;
                run_next       = '0;
                pos_next       = pos_reg + 1'b1;
            end else if (is_letter) begin
                ctl.shift = 1'b1;
                pos_next  = pos_reg + 1'b1;
                if (is_base) begin
                    run_next = (run_reg >= RUN_SAT) ? RUN_SAT : run_reg + 1'b1;
                    emit     = (run_next >= k);
                end else begin
                    run_next = '0;
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        if (emit) begin
            m_valid_next = 1'b1;
        end
    end

    kmerx_cell_row #(
        .MAX_K(MAX_K)
    ) u_row (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .k             (k),
        .fwd_word_next (fwd_word_next),
        .rev_word_next (rev_word_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ksel_reg      <= kmerx_pkg::SEL_K8;
            in_header_reg <= 1'b0;
            run_reg       <= '0;
            pos_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                ksel_reg <= cfg_wdata;
            end
            in_header_reg <= in_header_next;
            run_reg       <= run_next;
            pos_reg       <= pos_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            fwd_out_reg <= fwd_word_next;
            rev_out_reg <= rev_word_next;
            pos_out_reg <= pos_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {pos_out_reg, rev_out_reg, fwd_out_reg};

    `KMERX_ASSERT(a_run_saturates, run_reg <= RUN_SAT, "Run length exceeded saturation.")
    `KMERX_ASSERT(a_header_holds, (s_beat && in_header_reg && s_tdata != kmerx_pkg::CH_NEWLINE) |=> in_header_reg, "Header ended without a newline.")
    `KMERX_ASSERT(a_emit_shows, emit |=> (m_valid_reg && pos_out_reg == $past(pos_next)), "Emitted result not presented.")
    `KMERX_ASSERT(a_emit_needs_run, emit |-> (is_base && run_next >= k && !in_header_reg), "Result emitted without a full run.")
    `KMERX_ASSERT(a_no_accept_blocked, (m_valid_reg && !m_tready) |-> !s_tready, "Input accepted over a held result.")

endmodule
